// ===== rtl/qph_pkg.sv =====
package qph_pkg;

    localparam int QPH_SLOTS = 128;

    localparam int KEY_W  = 16;
    localparam int FUNC_W = 2;
    localparam int SIZE_W = 8;
    localparam int UPC_W  = 4;

    localparam logic [SIZE_W-1:0] TABLE_SIZE_RST = 8'd128;

    localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FN_REMOVE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd2;

    localparam logic REG_TABLE_SIZE = 1'b0;

    typedef logic [UPC_W-1:0] t_upc;

    localparam t_upc U_CLR   = 4'd0;
    localparam t_upc U_IDLE  = 4'd1;
    localparam t_upc U_DIV   = 4'd2;
    localparam t_upc U_PINIT = 4'd3;
    localparam t_upc U_RD    = 4'd4;
    localparam t_upc U_CHK   = 4'd5;
    localparam t_upc U_ADV   = 4'd6;
    localparam t_upc U_MISS  = 4'd7;
    localparam t_upc U_HIT   = 4'd8;
    localparam t_upc U_OUT   = 4'd9;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_ACC,
        C_CLR_MORE,
        C_DIV_MORE,
        C_BAD,
        C_HIT,
        C_MORE,
        C_OUT_FREE
    } t_cond;

    typedef struct packed {
        logic  in_rdy;
        logic  cnt_clr;
        logic  cnt_inc;
        logic  div_step;
        logic  probe_init;
        logic  probe_adv;
        logic  mem_rd;
        logic  mem_clr;
        logic  mem_upd;
        logic  out_load;
        t_cond cond;
        logic  wait_f;
        t_upc  target;
    } t_ctl;

    typedef struct packed {
        logic acc;
        logic clr_more;
        logic div_more;
        logic bad;
        logic hit;
        logic more;
        logic out_free;
    } t_stat;

    // Microcode ROM: one control word per step.
    function automatic t_ctl ucode(input t_upc upc);
        t_ctl w;
        w = '0;
        unique case (upc)
            U_CLR: begin
                w.mem_clr = 1'b1;
                w.cnt_inc = 1'b1;
                w.cond    = C_CLR_MORE;
                w.target  = U_CLR;
            end
            U_IDLE: begin
                w.in_rdy  = 1'b1;
                w.cnt_clr = 1'b1;
                w.cond    = C_ACC;
                w.target  = U_DIV;
                w.wait_f  = 1'b1;
            end
            U_DIV: begin
                w.div_step = 1'b1;
                w.cnt_inc  = 1'b1;
                w.cond     = C_DIV_MORE;
                w.target   = U_DIV;
            end
            U_PINIT: begin
                w.probe_init = 1'b1;
                w.cnt_clr    = 1'b1;
                w.cond       = C_BAD;
                w.target     = U_OUT;
            end
            U_RD: begin
                w.mem_rd = 1'b1;
                w.cond   = C_NEVER;
            end
            U_CHK: begin
                w.cond   = C_HIT;
                w.target = U_HIT;
            end
            U_ADV: begin
                w.probe_adv = 1'b1;
                w.cnt_inc   = 1'b1;
                w.cond      = C_MORE;
                w.target    = U_RD;
            end
            U_MISS: begin
                w.cond   = C_ALWAYS;
                w.target = U_OUT;
            end
            U_HIT: begin
                w.mem_upd = 1'b1;
                w.cond    = C_NEVER;
            end
            U_OUT: begin
                w.out_load = 1'b1;
                w.cond     = C_OUT_FREE;
                w.target   = U_IDLE;
                w.wait_f   = 1'b1;
            end
            default: begin
                w.cond   = C_ALWAYS;
                w.target = U_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/qph_if.sv =====
interface qph_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [15:0] key;

    modport source(output valid, output func, output key, input ready);
    modport sink(input valid, input func, input key, output ready);
endinterface

interface qph_out_if;
    logic       valid;
    logic       ready;
    logic       ok;
    logic [7:0] slot;

    modport source(output valid, output ok, output slot, input ready);
    modport sink(input valid, input ok, input slot, output ready);
endinterface

// ===== rtl/qph_ram.sv =====
module qph_ram #(
    parameter int DEPTH = 128,
    parameter int AW    = 7,
    parameter int DW    = 17
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/qph_seq.sv =====
module qph_seq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  qph_pkg::t_stat i_stat,
    output qph_pkg::t_ctl  o_ctl
);
    import qph_pkg::*;

    t_upc r_upc;
    t_upc n_upc;
    t_ctl ctl;
    logic taken;

    always_comb begin
        ctl = ucode(r_upc);
        unique case (ctl.cond)
            C_NEVER:    taken = 1'b0;
            C_ALWAYS:   taken = 1'b1;
            C_ACC:      taken = i_stat.acc;
            C_CLR_MORE: taken = i_stat.clr_more;
            C_DIV_MORE: taken = i_stat.div_more;
            C_BAD:      taken = i_stat.bad;
            C_HIT:      taken = i_stat.hit;
            C_MORE:     taken = i_stat.more;
            C_OUT_FREE: taken = i_stat.out_free;
            default:    taken = 1'b0;
        endcase
        if (taken) begin
            n_upc = ctl.target;
        end else if (ctl.wait_f) begin
            n_upc = r_upc;
        end else begin
            n_upc = r_upc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_CLR;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_ctl = ctl;

endmodule

// ===== rtl/qph_dp.sv =====
module qph_dp #(
    parameter int SLOTS = qph_pkg::QPH_SLOTS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  qph_pkg::t_ctl                 i_ctl,
    input  logic [qph_pkg::SIZE_W-1:0]    i_size,
    output qph_pkg::t_stat                o_stat,
    qph_in_if.sink                        i_in,
    qph_out_if.source                     o_out
);
    import qph_pkg::*;

    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = (IDX_W > SIZE_W) ? IDX_W : SIZE_W;
    localparam int DW    = KEY_W + 1;

    logic [FUNC_W-1:0] r_func, n_func;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [KEY_W-1:0]  r_dvd, n_dvd;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [SIZE_W-1:0] r_rem, n_rem;
    logic [SIZE_W-1:0] r_idx, n_idx;
    logic [SIZE_W-1:0] r_d, n_d;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_ok, n_ok;
    logic              r_out_valid, n_out_valid;
    logic              r_out_ok, n_out_ok;
    logic [SIZE_W-1:0] r_out_slot, n_out_slot;

    logic              acc;
    logic              out_free;
    logic              hit;
    logic [SIZE_W:0]   rem_sh;
    logic [SIZE_W:0]   idx_sum;
    logic [SIZE_W:0]   d_sum;
    logic [SIZE_W:0]   d_one;
    logic [SIZE_W:0]   probes;
    logic [SIZE_W-1:0] idx_next;
    logic [SIZE_W-1:0] d_next;
    logic [SIZE_W-1:0] rem_next;

    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [DW-1:0]     mem_wdata;
    logic [DW-1:0]     mem_rdata;

    qph_ram #(
        .DEPTH (SLOTS),
        .AW    (IDX_W),
        .DW    (DW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (i_ctl.mem_rd),
        .i_raddr (IDX_W'(r_idx)),
        .o_rdata (mem_rdata)
    );

    assign acc      = i_ctl.in_rdy & i_in.valid;
    assign out_free = !r_out_valid || o_out.ready;

    // Insert wants an empty slot; remove and lookup want an occupied slot with the key.
    assign hit = (r_func == FN_INSERT) ? !mem_rdata[KEY_W]
                                       : (mem_rdata[KEY_W] && (mem_rdata[KEY_W-1:0] == r_key));

    // One restoring step of key mod size, dividend bits taken from the top.
    assign rem_sh   = {r_rem, r_dvd[KEY_W-1]};
    assign rem_next = (rem_sh >= {1'b0, r_size}) ? SIZE_W'(rem_sh - {1'b0, r_size})
                                                 : rem_sh[SIZE_W-1:0];

    // Probe i+1 sits (2i+1) mod size past probe i; d carries that step.
    assign idx_sum  = {1'b0, r_idx} + {1'b0, r_d};
    assign idx_next = (idx_sum >= {1'b0, r_size}) ? SIZE_W'(idx_sum - {1'b0, r_size})
                                                  : idx_sum[SIZE_W-1:0];
    assign d_sum    = {1'b0, r_d} + 9'd2;
    assign d_one    = (d_sum >= {1'b0, r_size}) ? (d_sum - {1'b0, r_size}) : d_sum;
    assign d_next   = (d_one >= {1'b0, r_size}) ? SIZE_W'(d_one - {1'b0, r_size})
                                                : d_one[SIZE_W-1:0];
    assign probes   = {1'b0, r_cnt[SIZE_W-1:0]} + 9'd1;

    always_comb begin
        o_stat.acc      = acc;
        o_stat.clr_more = (r_cnt[IDX_W-1:0] != IDX_W'(SLOTS - 1));
        o_stat.div_more = (r_cnt[3:0] != 4'd15);
        o_stat.bad      = (r_func != FN_INSERT) && (r_func != FN_REMOVE)
                          && (r_func != FN_LOOKUP);
        o_stat.hit      = hit;
        o_stat.more     = (probes < {1'b0, r_size});
        o_stat.out_free = out_free;
    end

    always_comb begin
        mem_we    = i_ctl.mem_clr || (i_ctl.mem_upd && (r_func != FN_LOOKUP));
        mem_waddr = i_ctl.mem_clr ? r_cnt[IDX_W-1:0] : IDX_W'(r_idx);
        if (i_ctl.mem_clr) begin
            mem_wdata = '0;
        end else if (r_func == FN_INSERT) begin
            mem_wdata = {1'b1, r_key};
        end else begin
            mem_wdata = {1'b0, mem_rdata[KEY_W-1:0]};
        end
    end

    always_comb begin
        n_func      = r_func;
        n_key       = r_key;
        n_dvd       = r_dvd;
        n_size      = r_size;
        n_rem       = r_rem;
        n_idx       = r_idx;
        n_d         = r_d;
        n_cnt       = r_cnt;
        n_ok        = r_ok;
        n_out_valid = r_out_valid;
        n_out_ok    = r_out_ok;
        n_out_slot  = r_out_slot;

        if (acc) begin
            n_func = i_in.func;
            n_key  = i_in.key;
            n_dvd  = i_in.key;
            n_size = i_size;
            n_rem  = '0;
            n_ok   = 1'b0;
        end
        if (i_ctl.cnt_clr) begin
            n_cnt = '0;
        end else if (i_ctl.cnt_inc) begin
            n_cnt = r_cnt + 1'b1;
        end
        if (i_ctl.div_step) begin
            n_rem = rem_next;
            n_dvd = {r_dvd[KEY_W-2:0], 1'b0};
        end
        if (i_ctl.probe_init) begin
            n_idx = r_rem;
            n_d   = (r_size == 8'd1) ? 8'd0 : 8'd1;
        end
        if (i_ctl.probe_adv) begin
            n_idx = idx_next;
            n_d   = d_next;
        end
        if (i_ctl.mem_upd) begin
            n_ok = 1'b1;
        end
        if (i_ctl.out_load && out_free) begin
            n_out_valid = 1'b1;
            n_out_ok    = r_ok;
            n_out_slot  = r_ok ? (r_idx + 8'd1) : 8'd0;
        end else if (o_out.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_key      <= n_key;
        r_dvd      <= n_dvd;
        r_size     <= n_size;
        r_rem      <= n_rem;
        r_idx      <= n_idx;
        r_d        <= n_d;
        r_ok       <= n_ok;
        r_out_ok   <= n_out_ok;
        r_out_slot <= n_out_slot;
    end

    assign i_in.ready  = i_ctl.in_rdy;
    assign o_out.valid = r_out_valid;
    assign o_out.ok    = r_out_ok;
    assign o_out.slot  = r_out_slot;

    a_miss_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_ok) |-> (r_out_slot == 8'd0))
        else $error("miss result carries a nonzero slot");

    a_hit_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_ok) |-> (r_out_slot != 8'd0))
        else $error("hit result carries slot zero");

    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.mem_rd |-> (r_idx < r_size))
        else $error("probe index beyond table size");

    a_home_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.probe_init |-> (r_rem < r_size))
        else $error("home slot not reduced below table size");

endmodule

// ===== rtl/quadratic_probe_hash_table.sv =====
// Open-addressed hash table with quadratic probing.
// Requests arrive on i_in (func: insert, remove or lookup; key). Each request
// gives one beat on o_out: ok and the 1-based slot, or slot 0 when ok is low.
// Probe i of a key visits slot (key mod size + i*i) mod size, for at most size
// probes; remove and lookup scan the whole path and do not stop at holes.
// The table size is the APB register at offset 0 (reset 128, clamped to
// 1..SLOTS and at most 255); write it only while no request is in flight.
// After acceptance, key mod size is computed one bit per cycle, then each probe
// runs through a table read, a compare and an advance. The single table port
// and the bit-serial remainder set how long a request takes; one request is in
// work at a time.
// After reset a clearing pass empties every slot of the table before the
// first request is accepted. A finished result waits in the output register
// while the next request is accepted; the result of that request is held back
// until the waiting beat is taken.
module quadratic_probe_hash_table #(
    parameter int SLOTS = qph_pkg::QPH_SLOTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    qph_in_if.sink      i_in,
    qph_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import qph_pkg::*;

    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'((SLOTS < 255) ? SLOTS : 255);

    logic [SIZE_W-1:0] r_table_size;
    logic [SIZE_W-1:0] eff_size;
    logic              cfg_wr;
    t_ctl              ctl;
    t_stat             stat;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_TABLE_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= TABLE_SIZE_RST;
        end else if (cfg_wr) begin
            r_table_size <= pwdata[SIZE_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_TABLE_SIZE) ? {24'd0, r_table_size} : 32'd0;

    always_comb begin
        if (r_table_size == 8'd0) begin
            eff_size = 8'd1;
        end else if (r_table_size > SIZE_MAX) begin
            eff_size = SIZE_MAX;
        end else begin
            eff_size = r_table_size;
        end
    end

    qph_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctl   (ctl)
    );

    qph_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_size  (eff_size),
        .o_stat  (stat),
        .i_in    (i_in),
        .o_out   (o_out)
    );

endmodule
